// ----- sv/ramr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ramr_pkg;

	// Operand widths. The numerator is signed, the denominator one bit narrower.
	localparam int OPERAND_BITS = 16;
	localparam int NUM_W = OPERAND_BITS;
	localparam int DEN_W = OPERAND_BITS - 1;

	// Signed width of a cross product sum, and the width of its magnitude.
	localparam int PROD_W = 2 * OPERAND_BITS;
	localparam int MAG_W = 2 * OPERAND_BITS - 1;

	// Shared subtractor width: one bit above the magnitude for the divider trial.
	localparam int SUB_W = MAG_W + 1;

	// Counters for the common power of two and for the division steps.
	localparam int SHF_W = $clog2(MAG_W + 1);
	localparam int CNT_W = $clog2(MAG_W);

	// Result field widths, and the width used to sign-extend before truncation.
	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 31;
	localparam int WIDE_W = 64;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_MUL = 2'd1,
		CMD_INC = 2'd2,
		CMD_CMP = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [NUM_W-1:0]  a_num;
		logic        [DEN_W-1:0]  a_den;
		logic signed [NUM_W-1:0]  b_num;
		logic        [DEN_W-1:0]  b_den;
	} req_t;

	typedef struct packed {
		logic signed [RES_NUM_W-1:0] res_num;
		logic        [RES_DEN_W-1:0] res_den;
		logic                        is_equal;
		logic                        bad_operand;
	} rsp_t;

	// Operands handed to the reduction unit.
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [MAG_W-1:0] den;
	} red_in_t;

	// Reduced magnitudes returned by the reduction unit.
	typedef struct packed {
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
	} red_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEN,
		ST_NUM1,
		ST_NUM2,
		ST_SUM,
		ST_REDUCE,
		ST_WAIT,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		RS_IDLE,
		RS_GCD,
		RS_DIVN,
		RS_DIVD,
		RS_DONE
	} red_state_t;

endpackage

`default_nettype wire

// ----- sv/rational_add_mul_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A compare or a zero denominator goes straight from idle to the result strobe. Increment
// goes to the reduction at once; multiply and add first form the denominator and numerator
// products, add also sums the cross products, and a zero numerator skips the reduction.
// Throughput: one word at a time; busy stays high through the strobe cycle, so the next word
// is taken no earlier than the cycle after the strobe. The receiver cannot stall the result.
// arst_n returns both sequencers to idle at once, datapath registers are not reset.

module rational_add_mul_reduce (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire ramr_pkg::req_t  req,
	output      logic            busy,
	output      logic            done,
	output      ramr_pkg::rsp_t  rsp
);

	ramr_pkg::ctl_state_t st_q, st_nx;
	ramr_pkg::req_t       req_q;

	logic signed [ramr_pkg::PROD_W-1:0] num_q, prod_q;
	logic        [ramr_pkg::MAG_W-1:0]  den_q;
	logic                               neg_q, eq_q, bad_q;

	logic                                 accept;
	logic                                 bad_in;
	logic                                 red_go, red_fin;
	ramr_pkg::red_in_t                    red_in;
	ramr_pkg::red_out_t                   red_out;
	logic signed [ramr_pkg::NUM_W:0]      mx, my;
	logic signed [2*ramr_pkg::NUM_W+1:0]  prod_full;
	logic        [ramr_pkg::PROD_W-1:0]   abs_num;
	logic signed [ramr_pkg::PROD_W-1:0]   quo_s;
	logic signed [ramr_pkg::WIDE_W-1:0]   num_wide;
	logic        [ramr_pkg::WIDE_W-1:0]   den_wide;

	assign accept = start && !busy;

	// Denominator check for the incoming word: increment looks at a_den only.
	assign bad_in = (req.command == ramr_pkg::CMD_INC) ? (req.a_den == '0)
	                                                   : ((req.a_den == '0) || (req.b_den == '0));

	// Shared multiplier, registered before any use of its product.
	assign prod_full = mx * my;

	// Magnitude of the numerator, and the signed reduced numerator.
	assign abs_num = num_q[ramr_pkg::PROD_W-1] ? -num_q : num_q;
	assign quo_s   = {1'b0, red_out.num};

	assign red_in.mag = abs_num[ramr_pkg::MAG_W-1:0];
	assign red_in.den = den_q;

	// Output decode: handshake, multiplier operands and the reduction kick-off.
	always_comb begin
		busy   = (st_q != ramr_pkg::ST_IDLE);
		done   = (st_q == ramr_pkg::ST_DONE);
		red_go = 1'b0;
		mx     = {2'b00, req_q.a_den};
		my     = {2'b00, req_q.b_den};
		unique case (st_q)
			ramr_pkg::ST_NUM1: begin
				mx = {req_q.a_num[ramr_pkg::NUM_W-1], req_q.a_num};
				if (req_q.command == ramr_pkg::CMD_MUL) begin
					my = {req_q.b_num[ramr_pkg::NUM_W-1], req_q.b_num};
				end
			end
			ramr_pkg::ST_NUM2: begin
				mx = {req_q.b_num[ramr_pkg::NUM_W-1], req_q.b_num};
				my = {2'b00, req_q.a_den};
			end
			ramr_pkg::ST_REDUCE: begin
				red_go = (num_q != '0);
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ramr_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (req.command == ramr_pkg::CMD_CMP || bad_in)
						st_nx = ramr_pkg::ST_DONE;
					else if (req.command == ramr_pkg::CMD_INC)
						st_nx = ramr_pkg::ST_REDUCE;
					else
						st_nx = ramr_pkg::ST_DEN;
				end
			end
			ramr_pkg::ST_DEN:  st_nx = ramr_pkg::ST_NUM1;
			ramr_pkg::ST_NUM1: st_nx = ramr_pkg::ST_NUM2;
			ramr_pkg::ST_NUM2: begin
				st_nx = (req_q.command == ramr_pkg::CMD_ADD) ? ramr_pkg::ST_SUM
				                                             : ramr_pkg::ST_REDUCE;
			end
			ramr_pkg::ST_SUM:    st_nx = ramr_pkg::ST_REDUCE;
			ramr_pkg::ST_REDUCE: st_nx = (num_q == '0) ? ramr_pkg::ST_DONE : ramr_pkg::ST_WAIT;
			ramr_pkg::ST_WAIT:   if (red_fin) st_nx = ramr_pkg::ST_DONE;
			ramr_pkg::ST_DONE:   st_nx = ramr_pkg::ST_IDLE;
			default:             st_nx = ramr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ramr_pkg::ST_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	// Datapath: operand capture, products, sum and the signed reduced result.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ramr_pkg::ST_IDLE: begin
				if (accept) begin
					req_q <= req;
					eq_q  <= (req.command == ramr_pkg::CMD_CMP) &&
					         (req.a_num == req.b_num) && (req.a_den == req.b_den);
					bad_q <= (req.command != ramr_pkg::CMD_CMP) && bad_in;
					priority if (req.command == ramr_pkg::CMD_CMP || bad_in) begin
						num_q <= '0;
						den_q <= '0;
					end else begin
						num_q <= ramr_pkg::PROD_W'(req.a_num) + ramr_pkg::PROD_W'(req.a_den);
						den_q <= ramr_pkg::MAG_W'(req.a_den);
					end
				end
			end
			ramr_pkg::ST_DEN: begin
				prod_q <= prod_full[ramr_pkg::PROD_W-1:0];
			end
			ramr_pkg::ST_NUM1: begin
				den_q  <= prod_q[ramr_pkg::MAG_W-1:0];
				prod_q <= prod_full[ramr_pkg::PROD_W-1:0];
			end
			ramr_pkg::ST_NUM2: begin
				num_q  <= prod_q;
				prod_q <= prod_full[ramr_pkg::PROD_W-1:0];
			end
			ramr_pkg::ST_SUM: begin
				num_q <= num_q + prod_q;
			end
			ramr_pkg::ST_REDUCE: begin
				neg_q <= num_q[ramr_pkg::PROD_W-1];
			end
			ramr_pkg::ST_WAIT: begin
				if (red_fin) begin
					num_q <= neg_q ? -quo_s : quo_s;
					den_q <= red_out.den;
				end
			end
			default: begin
			end
		endcase
	end

	ramr_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (red_go),
		.red_in  (red_in),
		.fin     (red_fin),
		.red_out (red_out)
	);

	// Result word: sign-extend the numerator, zero-extend the denominator, then keep the field widths.
	assign num_wide = ramr_pkg::WIDE_W'(num_q);
	assign den_wide = ramr_pkg::WIDE_W'(den_q);

	assign rsp.res_num     = num_wide[ramr_pkg::RES_NUM_W-1:0];
	assign rsp.res_den     = den_wide[ramr_pkg::RES_DEN_W-1:0];
	assign rsp.is_equal    = eq_q;
	assign rsp.bad_operand = bad_q;

`ifndef SYNTHESIS
	// An accepted word makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not make the block busy");

	// A flagged operand always comes with a zeroed result.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.bad_operand) |-> (rsp.res_num == '0 && rsp.res_den == '0))
		else $error("bad operand result not zeroed");

	// Equality and operand error are never reported together.
	a_eq_bad: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.is_equal && rsp.bad_operand))
		else $error("equality and error flagged together");

	// The result strobe lasts a single cycle and frees the block.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

// ----- sv/ramr_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ramr_reduce (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire ramr_pkg::red_in_t   red_in,
	output      logic                fin,
	output      ramr_pkg::red_out_t  red_out
);

	ramr_pkg::red_state_t st_q, st_nx;

	logic [ramr_pkg::MAG_W-1:0] mag_q, den_q;
	logic [ramr_pkg::MAG_W-1:0] u_q, v_q, g_q;
	logic [ramr_pkg::MAG_W-1:0] rem_q, quo_q, num_res_q;
	logic [ramr_pkg::SHF_W-1:0] k_q;
	logic [ramr_pkg::CNT_W-1:0] cnt_q;

	// Shared subtractor: GCD difference or divider trial subtraction.
	logic [ramr_pkg::SUB_W-1:0] sa, sb;
	logic [ramr_pkg::SUB_W:0]   diff;
	logic                       borrow;
	logic                       same;
	logic                       div_last;
	logic [ramr_pkg::MAG_W-1:0] quo_nx, rem_nx;

	assign diff     = {1'b0, sa} - {1'b0, sb};
	assign borrow   = diff[ramr_pkg::SUB_W];
	assign same     = (diff == '0);
	assign div_last = (cnt_q == ramr_pkg::CNT_W'(ramr_pkg::MAG_W - 1));

	// One restoring division step: keep the difference when it does not borrow.
	assign quo_nx = {quo_q[ramr_pkg::MAG_W-2:0], ~borrow};
	assign rem_nx = borrow ? sa[ramr_pkg::MAG_W-1:0] : diff[ramr_pkg::MAG_W-1:0];

	// Output decode: operand selection for the subtractor and the finish strobe.
	always_comb begin
		fin = 1'b0;
		sa  = {1'b0, u_q};
		sb  = {1'b0, v_q};
		unique case (st_q)
			ramr_pkg::RS_DIVN, ramr_pkg::RS_DIVD: begin
				sa = {rem_q, quo_q[ramr_pkg::MAG_W-1]};
				sb = {1'b0, g_q};
			end
			ramr_pkg::RS_DONE: begin
				fin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign red_out.num = num_res_q;
	assign red_out.den = quo_q;

	// Next state.
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ramr_pkg::RS_IDLE: if (go) st_nx = ramr_pkg::RS_GCD;
			ramr_pkg::RS_GCD:  if (same) st_nx = ramr_pkg::RS_DIVN;
			ramr_pkg::RS_DIVN: if (div_last) st_nx = ramr_pkg::RS_DIVD;
			ramr_pkg::RS_DIVD: if (div_last) st_nx = ramr_pkg::RS_DONE;
			ramr_pkg::RS_DONE: st_nx = ramr_pkg::RS_IDLE;
			default:           st_nx = ramr_pkg::RS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ramr_pkg::RS_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	// Binary GCD, then both magnitudes divided by it, one quotient bit a cycle.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ramr_pkg::RS_IDLE: begin
				if (go) begin
					mag_q <= red_in.mag;
					den_q <= red_in.den;
					u_q   <= red_in.mag;
					v_q   <= red_in.den;
					k_q   <= '0;
				end
			end
			ramr_pkg::RS_GCD: begin
				priority if (same) begin
					g_q   <= u_q << k_q;
					rem_q <= '0;
					quo_q <= mag_q;
					cnt_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (borrow) begin
					// Keep the larger value in u so the subtraction stays positive.
					u_q <= v_q;
					v_q <= u_q;
				end else begin
					u_q <= diff[ramr_pkg::MAG_W:1];
				end
			end
			ramr_pkg::RS_DIVN: begin
				if (div_last) begin
					num_res_q <= quo_nx;
					rem_q     <= '0;
					quo_q     <= den_q;
					cnt_q     <= '0;
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ramr_pkg::RS_DIVD: begin
				cnt_q <= cnt_q + 1'b1;
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// The divisor found by the GCD loop is never zero.
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ramr_pkg::RS_DIVN) |-> (g_q != '0))
		else $error("reduction divisor is zero");

	// A new operand pair is only taken while the unit is idle.
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (st_q == ramr_pkg::RS_IDLE))
		else $error("reduction started while busy");

	// The reduced denominator is never zero.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (red_out.den != '0))
		else $error("reduced denominator is zero");
`endif

endmodule

`default_nettype wire
